FILE: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define QC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define QC_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error("forbidden condition");
`else
`define QC_ASSERT(lbl, clk, rstn, prop)
`define QC_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: design/qcmt_pkg.sv
// Shared types and constants of the quasi-clique membership tracker.
package qcmt_pkg;
    localparam logic [2:0] OP_WSLOT  = 3'd0;
    localparam logic [2:0] OP_WROW   = 3'd1;
    localparam logic [2:0] OP_ADD    = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    localparam int VERT_W  = 12;
    localparam int SLOT_W  = 16;
    localparam int CNT_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int EDGE_W  = 16;
    localparam int GAMMA_W = 17;
    localparam int PAIR_W  = 25;
    localparam int PROD_W  = GAMMA_W + PAIR_W;
    localparam int BOUND_W = PROD_W - 15;

    localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
    localparam logic [EDGE_W-1:0]  EDGE_MAX  = '1;
    localparam logic [GAMMA_W-1:0] GAMMA_ONE = 17'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_RST = 17'd58982;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             member;
        logic             cand;
    } vstate_t;
endpackage

FILE: design/qcmt_in_if.sv
// Command channel: one beat per operation.
interface qcmt_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [11:0] vertex;
    logic [15:0] edge_slot;
    logic [11:0] neighbour;
    logic [15:0] row_start;
    logic [11:0] row_length;
    modport source (output valid, opcode, vertex, edge_slot, neighbour, row_start, row_length,
                    input ready);
    modport sink (input valid, opcode, vertex, edge_slot, neighbour, row_start, row_length,
                  output ready);
endinterface

FILE: design/qcmt_out_if.sv
// Result channel: one beat per operation.
interface qcmt_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [12:0] set_size;
    logic [15:0] set_edges;
    logic [12:0] candidate_total;
    logic [11:0] neighbours_in_set;
    logic        is_member;
    logic        is_candidate;
    logic        may_join;
    modport source (output valid, status, set_size, set_edges, candidate_total,
                    neighbours_in_set, is_member, is_candidate, may_join, input ready);
    modport sink (input valid, status, set_size, set_edges, candidate_total,
                  neighbours_in_set, is_member, is_candidate, may_join, output ready);
endinterface

FILE: design/qcmt_cfg_if.sv
// Configuration write channel for the density register.
interface qcmt_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] density_gamma;
    modport source (output valid, density_gamma, input ready);
    modport sink (input valid, density_gamma, output ready);
endinterface

FILE: design/qcmt_ram.sv
// Generic simple dual-port RAM with registered read.
module qcmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/qcmt_rem.sv
// Slot reduction unit: maps a row start into the slot range by reciprocal multiplication.
module qcmt_rem #(
    parameter int EDGE_SLOTS = 65536
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [qcmt_pkg::SLOT_W-1:0]   value,
    output logic                          done,
    output logic [$clog2(EDGE_SLOTS)-1:0] rem
);
    import qcmt_pkg::*;

    localparam int SW = $clog2(EDGE_SLOTS);
    localparam bit WIDE = (EDGE_SLOTS >= (1 << SLOT_W));
    localparam logic [31:0] RECIP = WIDE ? 32'd0
                                         : 32'((64'd1 << 32) / 64'(EDGE_SLOTS) + 64'd1);
    localparam logic [SLOT_W-1:0] DIVISOR = WIDE ? '0 : SLOT_W'(EDGE_SLOTS);

    logic [SLOT_W-1:0]  value_reg;
    logic [SLOT_W+31:0] prod_reg;
    logic               busy_reg;
    logic [SLOT_W-1:0]  quot;
    logic [SLOT_W-1:0]  rem_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            value_reg <= value;
            prod_reg  <= (SLOT_W + 32)'(value) * (SLOT_W + 32)'(RECIP);
        end
    end

    // quotient is exact for a 16-bit value and a slot count below 65536
    assign quot     = prod_reg[SLOT_W+31:32];
    assign rem_full = WIDE ? value_reg
                           : value_reg - SLOT_W'(32'(quot) * 32'(DIVISOR));

    assign done = busy_reg;
    assign rem  = SW'(rem_full);
endmodule

FILE: design/qcmt_bound.sv
// Density bound pipeline: ceil(gamma * floor(n(n-1)/2)) over two register stages.
module qcmt_bound (
    input  logic                          clk,
    input  logic [qcmt_pkg::SIZE_W-1:0]   n,
    input  logic [qcmt_pkg::GAMMA_W-1:0]  gamma,
    output logic [qcmt_pkg::BOUND_W-1:0]  bound
);
    import qcmt_pkg::*;

    logic [PAIR_W-1:0]  pairs_reg;
    logic [GAMMA_W-1:0] gamma_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [2*SIZE_W-1:0] nn;
    logic [PROD_W:0]    rounded;

    assign nn = (2*SIZE_W)'(n) * (2*SIZE_W)'(n - SIZE_W'(1));

    always_ff @(posedge clk)
    begin
        pairs_reg <= PAIR_W'(nn >> 1);
        gamma_reg <= (gamma > GAMMA_ONE) ? GAMMA_ONE : gamma;
        prod_reg  <= PROD_W'(gamma_reg) * PROD_W'(pairs_reg);
    end

    assign rounded = (PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(65535);
    assign bound   = BOUND_W'(rounded >> 16);
endmodule

FILE: design/quasi_clique_membership_tracker.sv
// Top level: sequencer around the adjacency, row and vertex-state memories.
//  channel  | dir | beat contents
//  in_ch    | in  | opcode, vertex, edge_slot, neighbour, row_start, row_length
//  out_ch   | out | status, totals, named-vertex state, may_join
//  cfg_ch   | in  | density_gamma
// Query, slot write, unused opcode: read the vertex state, wait for the density bound, load the result.
// Row write: slot reduction, then the result path. Ignored add/remove: no state change, then the result path.
// Add/remove: update the vertex state, then walk the row; an in-range neighbour also gets its count updated.
// Reset and clear sweep all MAX_VERTICES entries of the vertex-state memory with in_ch.ready low;
// a clear then returns a result beat.
// A finished result waits in the output register; the next beat is taken meanwhile.
module quasi_clique_membership_tracker #(
    parameter int MAX_VERTICES = 4096,
    parameter int EDGE_SLOTS   = 65536
) (
    input logic   clk,
    input logic   rst_n,
    qcmt_in_if.sink    in_ch,
    qcmt_out_if.source out_ch,
    qcmt_cfg_if.sink   cfg_ch
);
    `include "assert_macros.svh"
    import qcmt_pkg::*;

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SW = $clog2(EDGE_SLOTS);
    localparam int ST_W = $bits(vstate_t);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RSET = 4'd1;
    localparam logic [3:0] S_RDV  = 4'd2;
    localparam logic [3:0] S_DEC  = 4'd3;
    localparam logic [3:0] S_WCHK = 4'd4;
    localparam logic [3:0] S_WNB  = 4'd5;
    localparam logic [3:0] S_WUPD = 4'd6;
    localparam logic [3:0] S_FRD  = 4'd7;
    localparam logic [3:0] S_FDAT = 4'd8;
    localparam logic [3:0] S_BW1  = 4'd9;
    localparam logic [3:0] S_BW2  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_CLR  = 4'd12;

    logic [3:0] state_reg, state_next;

    logic [2:0]        op_reg, op_next;
    logic [VERT_W-1:0] v_reg, v_next;
    logic              vok_reg, vok_next;
    logic [SLOT_W-1:0] rs_reg, rs_next;
    logic [CNT_W-1:0]  rl_reg, rl_next;
    logic              up_reg, up_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [AW-1:0]     w_reg, w_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic              status_reg, status_next;

    logic [SIZE_W-1:0] mtot_reg, mtot_next;
    logic [EDGE_W-1:0] edges_reg, edges_next;
    logic [SIZE_W-1:0] ctot_reg, ctot_next;
    logic [GAMMA_W-1:0] gamma_reg;

    logic [CNT_W-1:0] nis_reg, nis_next;
    logic             mem_reg, mem_next;
    logic             cand_reg, cand_next;

    logic              ov_reg, ov_next;
    logic              o_status_reg;
    logic [SIZE_W-1:0] o_size_reg;
    logic [EDGE_W-1:0] o_edges_reg;
    logic [SIZE_W-1:0] o_ctot_reg;
    logic [CNT_W-1:0]  o_nis_reg;
    logic              o_mem_reg, o_cand_reg, o_join_reg;
    logic              o_load;

    logic              in_fire;
    logic [AW-1:0]     vi;

    logic              adj_we;
    logic [SW-1:0]     adj_waddr, adj_raddr;
    logic [VERT_W-1:0] adj_wdata, adj_rdata;

    logic              row_we;
    logic [AW-1:0]     row_raddr;
    logic [SW+CNT_W-1:0] row_wdata, row_rdata;

    logic              st_we;
    logic [AW-1:0]     st_waddr, st_raddr;
    vstate_t           st_wdata, st_rdata;

    logic              rem_start, rem_done;
    logic [SW-1:0]     rem_val;

    logic [BOUND_W-1:0] bound;
    logic [CNT_W+EDGE_W:0] lhs;
    logic [CNT_W-1:0]   cnt_new;
    logic [EDGE_W:0]    edge_sum;

    assign in_fire      = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign vi           = AW'(v_reg);

    qcmt_ram #(.WIDTH(VERT_W), .DEPTH(EDGE_SLOTS)) u_adj (
        .clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
        .raddr(adj_raddr), .rdata(adj_rdata)
    );

    qcmt_ram #(.WIDTH(SW + CNT_W), .DEPTH(MAX_VERTICES)) u_row (
        .clk(clk), .we(row_we), .waddr(vi), .wdata(row_wdata),
        .raddr(row_raddr), .rdata(row_rdata)
    );

    qcmt_ram #(.WIDTH(ST_W), .DEPTH(MAX_VERTICES)) u_state (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    qcmt_rem #(.EDGE_SLOTS(EDGE_SLOTS)) u_rem (
        .clk(clk), .rst_n(rst_n), .start(rem_start), .value(rs_reg),
        .done(rem_done), .rem(rem_val)
    );

    qcmt_bound u_bound (
        .clk(clk), .n(mtot_reg + SIZE_W'(1)), .gamma(gamma_reg), .bound(bound)
    );

    assign adj_we    = in_fire && (in_ch.opcode == OP_WSLOT) && (32'(in_ch.edge_slot) < EDGE_SLOTS);
    assign adj_waddr = SW'(in_ch.edge_slot);
    assign adj_wdata = in_ch.neighbour;
    assign adj_raddr = slot_reg;

    assign row_we    = (state_reg == S_RSET) && rem_done;
    assign row_wdata = {rl_reg, rem_val};
    assign row_raddr = vi;

    assign lhs      = (CNT_W + EDGE_W + 1)'(nis_reg) + (CNT_W + EDGE_W + 1)'(edges_reg);
    assign edge_sum = (EDGE_W + 1)'(edges_reg) + (EDGE_W + 1)'(st_rdata.cnt);
    assign cnt_new  = up_reg ? ((st_rdata.cnt != CNT_MAX) ? st_rdata.cnt + CNT_W'(1) : st_rdata.cnt)
                             : ((st_rdata.cnt != '0) ? st_rdata.cnt - CNT_W'(1) : st_rdata.cnt);

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        v_next      = v_reg;
        vok_next    = vok_reg;
        rs_next     = rs_reg;
        rl_next     = rl_reg;
        up_next     = up_reg;
        slot_next   = slot_reg;
        left_next   = left_reg;
        w_next      = w_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        mtot_next   = mtot_reg;
        edges_next  = edges_reg;
        ctot_next   = ctot_reg;
        nis_next    = nis_reg;
        mem_next    = mem_reg;
        cand_next   = cand_reg;
        rem_start   = 1'b0;
        st_we       = 1'b0;
        st_waddr    = vi;
        st_wdata    = '0;
        st_raddr    = vi;
        o_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next     = in_ch.opcode;
                    v_next      = in_ch.vertex;
                    vok_next    = (32'(in_ch.vertex) < MAX_VERTICES);
                    rs_next     = in_ch.row_start;
                    rl_next     = in_ch.row_length;
                    status_next = 1'b0;
                    state_next  = S_FRD;
                    if (in_ch.opcode == OP_CLEAR)
                    begin
                        clr_next   = '0;
                        mtot_next  = '0;
                        edges_next = '0;
                        ctot_next  = '0;
                        state_next = S_CLR;
                    end
                    else if (32'(in_ch.vertex) < MAX_VERTICES)
                    begin
                        if (in_ch.opcode == OP_WROW)
                        begin
                            up_next    = 1'b0;
                            state_next = S_RSET;
                        end
                        else if (in_ch.opcode == OP_ADD || in_ch.opcode == OP_REMOVE)
                        begin
                            state_next = S_RDV;
                        end
                    end
                end
            end
            S_RSET:
            begin
                rem_start = !rem_done && !up_reg;
                up_next   = 1'b1;
                if (rem_done)
                begin
                    up_next    = 1'b0;
                    state_next = S_FRD;
                end
            end
            S_RDV:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                slot_next = row_rdata[SW-1:0];
                left_next = row_rdata[SW+CNT_W-1:SW];
                st_we     = 1'b1;
                if (op_reg == OP_ADD)
                begin
                    up_next = 1'b1;
                    if (st_rdata.member)
                    begin
                        st_wdata    = st_rdata;
                        status_next = 1'b1;
                        state_next  = S_FRD;
                    end
                    else
                    begin
                        st_wdata   = '{cnt: st_rdata.cnt, member: 1'b1, cand: 1'b0};
                        ctot_next  = ctot_reg - SIZE_W'(st_rdata.cand);
                        mtot_next  = mtot_reg + SIZE_W'(1);
                        edges_next = edge_sum[EDGE_W] ? EDGE_MAX : edge_sum[EDGE_W-1:0];
                        state_next = S_WCHK;
                    end
                end
                else
                begin
                    up_next = 1'b0;
                    if (!st_rdata.member)
                    begin
                        st_wdata    = st_rdata;
                        status_next = 1'b1;
                        state_next  = S_FRD;
                    end
                    else
                    begin
                        st_wdata   = '{cnt: st_rdata.cnt, member: 1'b0,
                                       cand: (st_rdata.cnt != '0) || st_rdata.cand};
                        ctot_next  = ctot_reg + SIZE_W'((st_rdata.cnt != '0) && !st_rdata.cand);
                        mtot_next  = mtot_reg - SIZE_W'(1);
                        edges_next = (edges_reg >= EDGE_W'(st_rdata.cnt))
                                     ? edges_reg - EDGE_W'(st_rdata.cnt) : '0;
                        state_next = S_WCHK;
                    end
                end
            end
            S_WCHK:
            begin
                state_next = (left_reg == '0) ? S_FRD : S_WNB;
            end
            S_WNB:
            begin
                left_next  = left_reg - CNT_W'(1);
                slot_next  = (slot_reg == SW'(EDGE_SLOTS - 1)) ? '0 : slot_reg + SW'(1);
                w_next     = AW'(adj_rdata);
                st_raddr   = AW'(adj_rdata);
                state_next = (32'(adj_rdata) < MAX_VERTICES) ? S_WUPD : S_WCHK;
            end
            S_WUPD:
            begin
                st_we    = 1'b1;
                st_waddr = w_reg;
                st_wdata = '{cnt: cnt_new, member: st_rdata.member, cand: st_rdata.cand};
                if (!st_rdata.member)
                begin
                    st_wdata.cand = (cnt_new != '0);
                    if ((cnt_new != '0) && !st_rdata.cand)
                    begin
                        ctot_next = ctot_reg + SIZE_W'(1);
                    end
                    else if ((cnt_new == '0) && st_rdata.cand)
                    begin
                        ctot_next = ctot_reg - SIZE_W'(1);
                    end
                end
                state_next = S_WCHK;
            end
            S_FRD:
            begin
                state_next = S_FDAT;
            end
            S_FDAT:
            begin
                nis_next   = vok_reg ? st_rdata.cnt : '0;
                mem_next   = vok_reg && st_rdata.member;
                cand_next  = vok_reg && st_rdata.cand;
                state_next = S_BW1;
            end
            S_BW1:
            begin
                state_next = S_BW2;
            end
            S_BW2:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    o_load     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLR:
            begin
                st_we    = 1'b1;
                st_waddr = clr_reg;
                st_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_VERTICES - 1))
                begin
                    // the sweep after reset ends without a result beat
                    state_next = (op_reg == OP_CLEAR) ? S_FRD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ov_next = o_load || (ov_reg && !out_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            op_reg    <= OP_QUERY;
            clr_reg   <= '0;
            up_reg    <= 1'b0;
            mtot_reg  <= '0;
            edges_reg <= '0;
            ctot_reg  <= '0;
            gamma_reg <= GAMMA_RST;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            clr_reg   <= clr_next;
            up_reg    <= up_next;
            mtot_reg  <= mtot_next;
            edges_reg <= edges_next;
            ctot_reg  <= ctot_next;
            ov_reg    <= ov_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                gamma_reg <= cfg_ch.density_gamma;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg      <= v_next;
        vok_reg    <= vok_next;
        rs_reg     <= rs_next;
        rl_reg     <= rl_next;
        slot_reg   <= slot_next;
        left_reg   <= left_next;
        w_reg      <= w_next;
        status_reg <= status_next;
        nis_reg    <= nis_next;
        mem_reg    <= mem_next;
        cand_reg   <= cand_next;
        if (o_load)
        begin
            o_status_reg <= status_reg;
            o_size_reg   <= mtot_reg;
            o_edges_reg  <= edges_reg;
            o_ctot_reg   <= ctot_reg;
            o_nis_reg    <= nis_reg;
            o_mem_reg    <= mem_reg;
            o_cand_reg   <= cand_reg;
            o_join_reg   <= vok_reg && ((BOUND_W + 1)'(lhs) >= (BOUND_W + 1)'(bound));
        end
    end

    assign out_ch.valid             = ov_reg;
    assign out_ch.status            = o_status_reg;
    assign out_ch.set_size          = o_size_reg;
    assign out_ch.set_edges         = o_edges_reg;
    assign out_ch.candidate_total   = o_ctot_reg;
    assign out_ch.neighbours_in_set = o_nis_reg;
    assign out_ch.is_member         = o_mem_reg;
    assign out_ch.is_candidate      = o_cand_reg;
    assign out_ch.may_join          = o_join_reg;

    `QC_NEVER(a_no_accept_in_clear, clk, rst_n, (state_reg == S_CLR) && in_ch.ready)
    `QC_ASSERT(a_accept_leaves_idle, clk, rst_n, in_fire |=> (state_reg != S_IDLE))
    `QC_NEVER(a_size_bound, clk, rst_n, 32'(mtot_reg) > MAX_VERTICES)
    `QC_NEVER(a_cand_bound, clk, rst_n, 32'(ctot_reg) > MAX_VERTICES)
endmodule
